/* sv/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, codes and the CRC-16/Modbus byte update shared by the Modbus RTU
// read-holding-registers master and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  // Largest register count a request may ask for
  localparam int unsigned MAX_QUANTITY = 125;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RX_BYTE = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_WORD    = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_CRC_ERR   = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_BAD_COUNT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_HDR   = 2'd1,
    FAULT_COUNT = 2'd2
  } fault_t;

  // Request frame byte slots, in send order
  typedef enum logic [2:0] {
    TX_ADDR   = 3'd0,
    TX_FUNC   = 3'd1,
    TX_REG_HI = 3'd2,
    TX_REG_LO = 3'd3,
    TX_QTY_HI = 3'd4,
    TX_QTY_LO = 3'd5,
    TX_CRC_LO = 3'd6,
    TX_CRC_HI = 3'd7
  } tx_slot_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  dev_addr;
    logic [15:0] base_reg;
    logic [6:0]  quantity;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  // Fold one byte into a CRC-16/Modbus value, reflected form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/modbus_rtu_read_holding_master_unit.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_unit
// Master side of a Modbus RTU read-holding-registers (function 3) exchange.
// ----------------------------------------------------------------------------
// A start beat emits the 8-byte request, one byte per output beat, with the
// CRC folded in one body byte per cycle while the sink takes them; the input
// side holds off for those 8 output beats, so a new start is taken only
// after the last request byte has gone out. Received bytes and timeouts
// yield at most one result each: a register word as each pair completes
// (provisional until the status says ok) and one status beat when the frame
// ends or times out. The result register is refilled in the same cycle it is
// taken, so with out_ready high and no request going out the block takes a
// received byte every clock. Bytes while idle, bytes after the frame, and
// timeouts while idle give no result.
`default_nettype none

module modbus_rtu_read_holding_master_unit
  import mbrtu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam logic [6:0] QtyMax = 7'(MAX_QUANTITY);

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Request sequencer
  logic        tx_busy_r, tx_busy_nxt;
  logic [2:0]  tx_cnt_r, tx_cnt_nxt;
  logic [15:0] tx_crc_r, tx_crc_nxt;
  logic [15:0] tx_reg_r, tx_reg_nxt;

  // Response tracking
  logic        waiting_r, waiting_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [6:0]  qty_r, qty_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  fault_t      fault_r, fault_nxt;
  logic [7:0]  hi_byte_r, hi_byte_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic        slot_free;
  logic        in_acc;
  logic        tx_emit;
  logic [6:0]  qty_clamp;
  logic [8:0]  frame_len;
  logic [8:0]  pos_ahead;
  logic [7:0]  tx_byte_sel;
  logic [7:0]  word_off;
  status_t     fin_status;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !tx_busy_r && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign tx_emit   = tx_busy_r && slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign qty_clamp = (in_data.quantity > QtyMax) ? QtyMax : in_data.quantity;
  assign frame_len = 9'd5 + {1'b0, qty_r, 1'b0};
  assign pos_ahead = {1'b0, pos_r} + 9'd2;
  assign word_off  = pos_r - 8'd4;

  // Pick the request byte for the current slot
  always_comb begin
    case (tx_slot_t'(tx_cnt_r))
      TX_ADDR:   tx_byte_sel = addr_r;
      TX_FUNC:   tx_byte_sel = FUNC_READ;
      TX_REG_HI: tx_byte_sel = tx_reg_r[15:8];
      TX_REG_LO: tx_byte_sel = tx_reg_r[7:0];
      TX_QTY_HI: tx_byte_sel = 8'h00;
      TX_QTY_LO: tx_byte_sel = {1'b0, qty_r};
      TX_CRC_LO: tx_byte_sel = tx_crc_r[7:0];
      TX_CRC_HI: tx_byte_sel = tx_crc_r[15:8];
      default:   tx_byte_sel = 8'h00;
    endcase
  end

  // Final status, crc first, then header, then byte count
  always_comb begin
    if ({in_data.rx_byte, crc_lo_r} != crc_r) begin
      fin_status = ST_CRC_ERR;
    end else if (fault_r == FAULT_HDR) begin
      fin_status = ST_BAD_HDR;
    end else if (fault_r == FAULT_COUNT) begin
      fin_status = ST_BAD_COUNT;
    end else begin
      fin_status = ST_OK;
    end
  end

  // Next state and result
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    tx_busy_nxt   = tx_busy_r;
    tx_cnt_nxt    = tx_cnt_r;
    tx_crc_nxt    = tx_crc_r;
    tx_reg_nxt    = tx_reg_r;
    waiting_nxt   = waiting_r;
    addr_nxt      = addr_r;
    qty_nxt       = qty_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    fault_nxt     = fault_r;
    hi_byte_nxt   = hi_byte_r;
    crc_lo_nxt    = crc_lo_r;

    // Send one request byte per free output slot
    if (tx_emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt           = '0;
      out_data_nxt.kind      = KIND_TX_BYTE;
      out_data_nxt.tx_byte   = tx_byte_sel;
      out_data_nxt.last      = (tx_cnt_r == TX_CRC_HI);
      // Fold only the six body bytes; hold the CRC while it goes out
      if (tx_cnt_r < TX_CRC_LO) begin
        tx_crc_nxt = crc_byte(tx_crc_r, tx_byte_sel);
      end
      tx_cnt_nxt             = tx_cnt_r + 3'd1;
      if (tx_cnt_r == TX_CRC_HI) begin
        tx_busy_nxt = 1'b0;
      end
    end

    if (in_acc) begin
      case (opcode_t'(in_data.opcode))
        OP_START: begin
          tx_busy_nxt = 1'b1;
          tx_cnt_nxt  = TX_ADDR;
          tx_crc_nxt  = CRC_INIT;
          tx_reg_nxt  = in_data.base_reg;
          waiting_nxt = 1'b1;
          addr_nxt    = in_data.dev_addr;
          qty_nxt     = qty_clamp;
          pos_nxt     = 8'd0;
          crc_nxt     = CRC_INIT;
          fault_nxt   = FAULT_NONE;
          hi_byte_nxt = 8'd0;
          crc_lo_nxt  = 8'd0;
        end
        OP_TIMEOUT: begin
          if (waiting_r) begin
            waiting_nxt         = 1'b0;
            out_valid_nxt       = 1'b1;
            out_data_nxt        = '0;
            out_data_nxt.kind   = KIND_STATUS;
            out_data_nxt.status = ST_SHORT;
            out_data_nxt.last   = 1'b1;
          end
        end
        OP_RX_BYTE: begin
          if (waiting_r) begin
            pos_nxt = pos_r + 8'd1;
            if (pos_ahead < frame_len) begin
              // Body byte: fold into the CRC, check the header and byte count, or collect a register word
              crc_nxt = crc_byte(crc_r, in_data.rx_byte);
              if (pos_r == 8'd0) begin
                if (in_data.rx_byte != addr_r) fault_nxt = FAULT_HDR;
              end else if (pos_r == 8'd1) begin
                if (in_data.rx_byte != FUNC_READ) fault_nxt = FAULT_HDR;
              end else if (pos_r == 8'd2) begin
                if (fault_r == FAULT_NONE && in_data.rx_byte != {qty_r, 1'b0}) begin
                  fault_nxt = FAULT_COUNT;
                end
              end else if (pos_r[0]) begin
                hi_byte_nxt = in_data.rx_byte;
              end else begin
                out_valid_nxt          = 1'b1;
                out_data_nxt           = '0;
                out_data_nxt.kind      = KIND_WORD;
                out_data_nxt.reg_value = {hi_byte_r, in_data.rx_byte};
                out_data_nxt.reg_index = word_off[7:1];
              end
            end else if (pos_ahead == frame_len) begin
              crc_lo_nxt = in_data.rx_byte;
            end else begin
              // Closing CRC byte: report
              waiting_nxt         = 1'b0;
              out_valid_nxt       = 1'b1;
              out_data_nxt        = '0;
              out_data_nxt.kind   = KIND_STATUS;
              out_data_nxt.status = fin_status;
              out_data_nxt.last   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tx_busy_r   <= 1'b0;
      tx_cnt_r    <= TX_ADDR;
      waiting_r   <= 1'b0;
      addr_r      <= 8'd0;
      qty_r       <= 7'd0;
      pos_r       <= 8'd0;
      crc_r       <= CRC_INIT;
      fault_r     <= FAULT_NONE;
      hi_byte_r   <= 8'd0;
      crc_lo_r    <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      tx_busy_r   <= tx_busy_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      waiting_r   <= waiting_nxt;
      addr_r      <= addr_nxt;
      qty_r       <= qty_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      fault_r     <= fault_nxt;
      hi_byte_r   <= hi_byte_nxt;
      crc_lo_r    <= crc_lo_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    tx_crc_r   <= tx_crc_nxt;
    tx_reg_r   <= tx_reg_nxt;
  end

endmodule

`default_nettype wire

/* sv/mbrtu_checker.sv */
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks for the Modbus RTU read-holding-registers master.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_checker
  import mbrtu_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A start blocks input while the request goes out
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_START |=> !in_ready)
    else $error("input taken during request send");

  // Status beats always close
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.last)
    else $error("status beat without last");

  // Register words carry no request byte and never close
  a_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_WORD |-> !out_data.last && out_data.tx_byte == 8'h00)
    else $error("malformed register word beat");

endmodule

bind modbus_rtu_read_holding_master_unit mbrtu_checker u_mbrtu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
